### rtl/rs_systematic_encoder_gf256_core_assert.svh
// Assertion macros for the Reed-Solomon encoder core.
`ifndef RS_SYSTEMATIC_ENCODER_GF256_CORE_ASSERT_SVH
`define RS_SYSTEMATIC_ENCODER_GF256_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RSENC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RSENC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rsenc_pkg.sv
// Shared types, constants and GF(2^8) arithmetic for the Reed-Solomon encoder.
`timescale 1ns / 1ps

package rsenc_pkg;

    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 6;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int NUM_COEF_REGS = 8;
    localparam int COEF_PER_REG  = CFG_DATA_W / BYTE_W;

    // Low byte of the field reduction polynomial 0x11D.
    localparam logic [BYTE_W-1:0] GF_POLY = 8'h1D;

    // One message beat.
    typedef struct packed {
        logic [BYTE_W-1:0] msg_byte;
        logic              last_byte;
    } t_in_beat;

    // One parity beat.
    typedef struct packed {
        logic [BYTE_W-1:0] parity_byte;
        logic [IDX_W-1:0]  parity_index;
        logic              last_parity;
    } t_out_beat;

    // Shift-and-add multiply in GF(2^8), eight narrow steps.
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = x[BYTE_W-1] ? ({x[BYTE_W-2:0], 1'b0} ^ GF_POLY) : {x[BYTE_W-2:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

### rtl/rsenc_lfsr.sv
// Generator coefficient registers and the parity feedback shift register.
`timescale 1ns / 1ps

module rsenc_lfsr #(
    parameter int NPAR = 30
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rsenc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rsenc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_step,
    input  rsenc_pkg::t_in_beat                 i_beat,
    output logic [NPAR*rsenc_pkg::BYTE_W-1:0]   o_par
);

    localparam int BW = rsenc_pkg::BYTE_W;

    logic [BW-1:0] r_coef [NPAR];
    logic [BW-1:0] r_par  [NPAR];
    logic [BW-1:0] n_par  [NPAR];
    logic [BW-1:0] gate;

    // Coefficient k lives in byte k mod 8 of register k div 8.
    for (genvar k = 0; k < NPAR; k++) begin : g_coef
        localparam int REG_SEL  = k / rsenc_pkg::COEF_PER_REG;
        localparam int BYTE_SEL = k % rsenc_pkg::COEF_PER_REG;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_coef[k] <= '0;
            end else if (i_cfg_we &&
                         i_cfg_idx == rsenc_pkg::CFG_IDX_W'(REG_SEL)) begin
                r_coef[k] <= i_cfg_data[BYTE_SEL*BW +: BW];
            end
        end
    end

    // Feedback: every stage adds the gate times its coefficient.
    assign gate = i_beat.msg_byte ^ r_par[NPAR-1];

    always_comb begin
        n_par[0] = rsenc_pkg::gf_mul(gate, r_coef[0]);
        for (int k = 1; k < NPAR; k++) begin
            n_par[k] = r_par[k-1] ^ rsenc_pkg::gf_mul(gate, r_coef[k]);
        end
    end

    // The stage clears after the last symbol; its parity goes to the output buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPAR; k++) begin
                r_par[k] <= '0;
            end
        end else if (i_step) begin
            for (int k = 0; k < NPAR; k++) begin
                r_par[k] <= i_beat.last_byte ? '0 : n_par[k];
            end
        end
    end

    for (genvar k = 0; k < NPAR; k++) begin : g_out
        assign o_par[k*BW +: BW] = n_par[k];
    end

endmodule

### rtl/rsenc_obuf.sv
// Output buffer that streams a finished parity block one byte per beat.
`timescale 1ns / 1ps

module rsenc_obuf #(
    parameter int NPAR = 30
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [NPAR*rsenc_pkg::BYTE_W-1:0]   i_par,
    output logic                                o_free,
    output logic                                o_valid,
    input  logic                                i_ready,
    output rsenc_pkg::t_out_beat                o_beat
);

    localparam int BW = rsenc_pkg::BYTE_W;
    localparam int IW = rsenc_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NPAR - 1);

    logic [BW-1:0] r_sbuf [NPAR];
    logic [IW-1:0] r_cnt;
    logic          r_busy;
    logic          take;
    logic          at_end;

    assign take   = r_busy && i_ready;
    assign at_end = (r_cnt == LAST_IDX);

    // A new block may load when empty or when the final beat leaves now.
    assign o_free = !r_busy || (take && at_end);

    // Control: beat counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (take) begin
            r_busy <= !at_end;
            r_cnt  <= at_end ? '0 : r_cnt + IW'(1);
        end
    end

    // Payload: parity bytes shift toward the head entry.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < NPAR; k++) begin
                r_sbuf[k] <= i_par[k*BW +: BW];
            end
        end else if (take) begin
            for (int k = 0; k < NPAR - 1; k++) begin
                r_sbuf[k] <= r_sbuf[k+1];
            end
        end
    end

    assign o_valid             = r_busy;
    assign o_beat.parity_byte  = r_sbuf[0];
    assign o_beat.parity_index = r_cnt;
    assign o_beat.last_parity  = at_end;

endmodule

### rtl/rs_systematic_encoder_gf256_core.sv
// The first parity beat is valid in the cycle after the last message beat is taken.
// Throughput: one message beat per cycle, a final beat waiting for buffer room;
// a block of NPAR parity beats drains at one beat per cycle while i_out_ready is
// high; the output buffer sets the pace for messages shorter than NPAR symbols.
// Reset (synchronous, active low) clears the coefficients, parity and buffer control state.
`timescale 1ns / 1ps

module rs_systematic_encoder_gf256_core #(
    parameter int NPAR = 30
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rsenc_pkg::t_in_beat                i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rsenc_pkg::t_out_beat               o_out_data,
    input  logic                               i_cfg_we,
    input  logic [rsenc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rsenc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

`include "rs_systematic_encoder_gf256_core_assert.svh"

    localparam logic [rsenc_pkg::IDX_W-1:0] LAST_IDX = rsenc_pkg::IDX_W'(NPAR - 1);

    logic                                 step;
    logic                                 load;
    logic                                 buf_free;
    logic [NPAR*rsenc_pkg::BYTE_W-1:0]    par;

    // Non-final beats always go in; a final beat waits for buffer room.
    assign o_in_ready = buf_free || !i_in_data.last_byte;
    assign step       = i_in_valid && o_in_ready;
    assign load       = step && i_in_data.last_byte;

    rsenc_lfsr #(
        .NPAR (NPAR)
    ) u_lfsr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_beat     (i_in_data),
        .o_par      (par)
    );

    rsenc_obuf #(
        .NPAR (NPAR)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_par   (par),
        .o_free  (buf_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_data)
    );

    // A final message beat starts a parity block at index zero.
    `RSENC_ASSERT_NEXT(a_block_start, load, o_out_valid && o_out_data.parity_index == '0, "parity block did not start at index zero")

    // The last-parity flag marks exactly the top index.
    `RSENC_ASSERT_NOW(a_last_flag, o_out_valid && o_out_data.last_parity, o_out_data.parity_index == LAST_IDX, "last parity flag on wrong index")

    // Taken beats inside a block step the index by one.
    `RSENC_ASSERT_NEXT(a_index_step, o_out_valid && i_out_ready && !o_out_data.last_parity, o_out_valid && o_out_data.parity_index == $past(o_out_data.parity_index) + rsenc_pkg::IDX_W'(1), "parity index did not advance")

    // No new block may overwrite one that is still draining.
    `RSENC_ASSERT_NOW(a_no_overrun, o_out_valid && !(i_out_ready && o_out_data.last_parity), !load, "parity block loaded over a busy buffer")

endmodule
